// ===== hdl/assert_macros.svh =====
// Assertion macros used by the broadcast source index divider.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define BSI_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define BSI_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define BSI_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define BSI_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/bsi_pkg.sv =====
// Shared constants and types of the broadcast source index block.
package bsi_pkg;

  localparam int MAX_RANK   = 4;
  localparam int INDEX_BITS = 24;
  localparam int SIZE_REGS  = 4;
  localparam int SIZE_BITS  = 16;
  localparam int RANK_BITS  = 3;
  localparam int MASK_BITS  = 4;
  localparam int ADDR_BITS  = 5;
  localparam int DATA_BITS  = 32;

  // Register indexes, at byte address four times the index.
  localparam logic [2:0] REG_RANK  = 3'd0;
  localparam logic [2:0] REG_SIZE0 = 3'd1;
  localparam logic [2:0] REG_SIZE1 = 3'd2;
  localparam logic [2:0] REG_SIZE2 = 3'd3;
  localparam logic [2:0] REG_SIZE3 = 3'd4;
  localparam logic [2:0] REG_MASK  = 3'd5;

  // Configuration as seen by the datapath.
  typedef struct packed {
    logic [RANK_BITS-1:0]                eff_rank;
    logic [SIZE_REGS-1:0][SIZE_BITS-1:0] size;
    logic [MASK_BITS-1:0]                mask;
  } cfg_t;

endpackage

// ===== hdl/broadcast_source_index.sv =====
// Top level of the broadcast source index address generator.
//
// A transaction on the input channel is accepted at a rising clock edge where
// start is high and busy is low; busy never rises, so an index can be given
// in every cycle. in_target_index is a flat row-major target index.
// Each result appears on out_source_offset for exactly one cycle, marked by
// out_valid, in the order the indexes were accepted.
// Every dimension takes one pipelined divider stage per index bit, then one
// multiply-accumulate stage. Throughput is one transaction per cycle.
// Dimensions beyond the configured rank pass through as division by one.
// The receiver cannot stall; results are not held.
// Reset clears the valid bits of the pipeline and loads the register reset
// values: rank four, every size one, no broadcast dimensions.
// Registers must be written over the APB-style port only while the pipeline
// is empty; the block does not enforce this. Every stage uses them directly.
module broadcast_source_index #(
  parameter int MAX_RANK   = bsi_pkg::MAX_RANK,
  parameter int INDEX_BITS = bsi_pkg::INDEX_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [INDEX_BITS-1:0]         in_target_index,
  output logic                          out_valid,
  output logic [INDEX_BITS-1:0]         out_source_offset,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bsi_pkg::ADDR_BITS-1:0] paddr,
  input  logic [bsi_pkg::DATA_BITS-1:0] pwdata,
  output logic [bsi_pkg::DATA_BITS-1:0] prdata,
  output logic                          pready
);

  localparam int IW = INDEX_BITS;
  localparam int VW = bsi_pkg::SIZE_BITS;

  bsi_pkg::cfg_t cfg;

  logic          seg_valid  [MAX_RANK+1];
  logic [IW-1:0] seg_index  [MAX_RANK+1];
  logic [IW-1:0] seg_offset [MAX_RANK+1];
  logic [IW-1:0] seg_stride [MAX_RANK+1];

  assign busy = 1'b0;

  bsi_regs #(.MAX_RANK(MAX_RANK)) u_regs (
    .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
  );

  // Pipeline entry.
  assign seg_valid[0]  = start && !busy;
  assign seg_index[0]  = in_target_index;
  assign seg_offset[0] = '0;
  assign seg_stride[0] = IW'(1);

  // Segment s handles dimension MAX_RANK-1-s, innermost first.
  for (genvar s = 0; s < MAX_RANK; s++) begin : g_dim
    localparam int J = MAX_RANK - 1 - s;
    logic          active, bcast, use_dim;
    logic [VW-1:0] size_raw, size_eff;
    logic          dv;
    logic [IW-1:0] quo;
    logic [VW-1:0] rem;
    logic [2*IW-1:0] side;

    if (J < bsi_pkg::SIZE_REGS) begin : g_real
      assign active   = J < int'(cfg.eff_rank);
      assign bcast    = cfg.mask[J];
      assign size_raw = cfg.size[J];
    end else begin : g_absent
      assign active   = 1'b0;
      assign bcast    = 1'b1;
      assign size_raw = '0;
    end

    // A zero size, or an unused dimension, divides by one.
    assign size_eff = (active && size_raw != '0) ? size_raw : VW'(1);
    assign use_dim  = active && !bcast;

    bsi_divider #(.DW(IW), .VW(VW), .SW(2 * IW)) u_div (
      .clk(clk), .rst_n(rst_n),
      .valid_i(seg_valid[s]), .dividend_i(seg_index[s]), .divisor_i(size_eff),
      .side_i({seg_offset[s], seg_stride[s]}),
      .valid_o(dv), .quotient_o(quo), .remainder_o(rem), .side_o(side)
    );

    bsi_accum #(.IW(IW), .VW(VW)) u_acc (
      .clk(clk), .rst_n(rst_n),
      .valid_i(dv), .index_i(quo), .pos_i(rem),
      .offset_i(side[2*IW-1:IW]), .stride_i(side[IW-1:0]),
      .use_i(use_dim), .size_i(size_eff),
      .valid_o(seg_valid[s+1]), .index_o(seg_index[s+1]),
      .offset_o(seg_offset[s+1]), .stride_o(seg_stride[s+1])
    );
  end

  assign out_valid         = seg_valid[MAX_RANK];
  assign out_source_offset = seg_offset[MAX_RANK];

endmodule

// ===== hdl/bsi_regs.sv =====
// Configuration registers with an APB-style access port.
module bsi_regs #(
  parameter int MAX_RANK = bsi_pkg::MAX_RANK
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bsi_pkg::ADDR_BITS-1:0]  paddr,
  input  logic [bsi_pkg::DATA_BITS-1:0]  pwdata,
  output logic [bsi_pkg::DATA_BITS-1:0]  prdata,
  output logic                           pready,
  output bsi_pkg::cfg_t                  cfg
);

  localparam int SB = bsi_pkg::SIZE_BITS;
  localparam int RB = bsi_pkg::RANK_BITS;
  localparam int MB = bsi_pkg::MASK_BITS;
  localparam int RANK_LIM = (MAX_RANK < bsi_pkg::SIZE_REGS) ? MAX_RANK : bsi_pkg::SIZE_REGS;

  logic [RB-1:0]                              rank_r;
  logic [bsi_pkg::SIZE_REGS-1:0][SB-1:0]      size_r;
  logic [MB-1:0]                              mask_r;
  logic [2:0]                                 reg_idx;
  logic                                       wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[bsi_pkg::ADDR_BITS-1:2];
  assign wr_en   = psel && penable && pwrite;

  // Register writes; an address beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rank_r <= RB'(4);
      size_r <= {bsi_pkg::SIZE_REGS{SB'(1)}};
      mask_r <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        bsi_pkg::REG_RANK:  rank_r    <= pwdata[RB-1:0];
        bsi_pkg::REG_SIZE0: size_r[0] <= pwdata[SB-1:0];
        bsi_pkg::REG_SIZE1: size_r[1] <= pwdata[SB-1:0];
        bsi_pkg::REG_SIZE2: size_r[2] <= pwdata[SB-1:0];
        bsi_pkg::REG_SIZE3: size_r[3] <= pwdata[SB-1:0];
        bsi_pkg::REG_MASK:  mask_r    <= pwdata[MB-1:0];
        default: ;
      endcase
    end
  end

  // Read data.
  always_comb begin
    prdata = '0;
    case (reg_idx)
      bsi_pkg::REG_RANK:  prdata[RB-1:0] = rank_r;
      bsi_pkg::REG_SIZE0: prdata[SB-1:0] = size_r[0];
      bsi_pkg::REG_SIZE1: prdata[SB-1:0] = size_r[1];
      bsi_pkg::REG_SIZE2: prdata[SB-1:0] = size_r[2];
      bsi_pkg::REG_SIZE3: prdata[SB-1:0] = size_r[3];
      bsi_pkg::REG_MASK:  prdata[MB-1:0] = mask_r;
      default:            prdata = '0;
    endcase
  end

  // The rank is clamped to the number of dimensions the datapath has.
  always_comb begin
    cfg.size = size_r;
    cfg.mask = mask_r;
    if (int'(rank_r) > RANK_LIM) begin
      cfg.eff_rank = RB'(RANK_LIM);
    end else begin
      cfg.eff_rank = rank_r;
    end
  end

endmodule

// ===== hdl/bsi_divider.sv =====
// Pipelined restoring divider, one quotient bit per stage, with sideband data.
`include "assert_macros.svh"
module bsi_divider #(
  parameter int DW = bsi_pkg::INDEX_BITS,
  parameter int VW = bsi_pkg::SIZE_BITS,
  parameter int SW = 2 * bsi_pkg::INDEX_BITS
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          valid_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [DW-1:0] quotient_o,
  output logic [VW-1:0] remainder_o,
  output logic [SW-1:0] side_o
);

  logic          vld_r  [DW];
  logic [VW-1:0] rem_r  [DW];
  logic [DW-1:0] work_r [DW];
  logic [SW-1:0] side_r [DW];

  // Each stage shifts in one dividend bit and subtracts where it fits.
  for (genvar k = 0; k < DW; k++) begin : g_stage
    logic          vld_in;
    logic [VW-1:0] rem_in;
    logic [DW-1:0] work_in;
    logic [SW-1:0] side_in;
    logic [VW:0]   trial;
    logic          fits;
    logic [VW-1:0] rem_nxt;
    logic [DW-1:0] work_nxt;

    if (k == 0) begin : g_first
      assign vld_in  = valid_i;
      assign rem_in  = '0;
      assign work_in = dividend_i;
      assign side_in = side_i;
    end else begin : g_next
      assign vld_in  = vld_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign work_in = work_r[k-1];
      assign side_in = side_r[k-1];
    end

    assign trial    = {rem_in, work_in[DW-1]};
    assign fits     = trial >= {1'b0, divisor_i};
    assign rem_nxt  = fits ? VW'(trial - {1'b0, divisor_i}) : trial[VW-1:0];
    assign work_nxt = {work_in[DW-2:0], fits};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k]  <= rem_nxt;
      work_r[k] <= work_nxt;
      side_r[k] <= side_in;
    end
  end

  assign valid_o     = vld_r[DW-1];
  assign quotient_o  = work_r[DW-1];
  assign remainder_o = rem_r[DW-1];
  assign side_o      = side_r[DW-1];

  // The remainder stays below the divisor, and every valid result follows a valid input.
  `BSI_ASSERT_IMP(a_rem_below, clk, rst_n, valid_o && divisor_i != '0, remainder_o < divisor_i)
  `BSI_ASSERT_IMP(a_latency, clk, rst_n, valid_o, $past(valid_i, DW))
  `BSI_ASSERT_IMP(a_unit_div, clk, rst_n, valid_o && divisor_i == VW'(1), remainder_o == '0)

endmodule

// ===== hdl/bsi_accum.sv =====
// Weights one dimension position by its source stride and updates the stride.
module bsi_accum #(
  parameter int IW = bsi_pkg::INDEX_BITS,
  parameter int VW = bsi_pkg::SIZE_BITS
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          valid_i,
  input  logic [IW-1:0] index_i,
  input  logic [VW-1:0] pos_i,
  input  logic [IW-1:0] offset_i,
  input  logic [IW-1:0] stride_i,
  input  logic          use_i,
  input  logic [VW-1:0] size_i,
  output logic          valid_o,
  output logic [IW-1:0] index_o,
  output logic [IW-1:0] offset_o,
  output logic [IW-1:0] stride_o
);

  logic          valid_r;
  logic [IW-1:0] index_r, offset_r, stride_r;
  logic [IW-1:0] offset_nxt, stride_nxt;
  logic [IW+VW-1:0] term, scaled;

  // One multiply for the term and one for the next stride, side by side.
  assign term   = pos_i * stride_i;
  assign scaled = stride_i * size_i;
  assign offset_nxt = use_i ? IW'(offset_i + term[IW-1:0]) : offset_i;
  assign stride_nxt = use_i ? scaled[IW-1:0] : stride_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    index_r  <= index_i;
    offset_r <= offset_nxt;
    stride_r <= stride_nxt;
  end

  assign valid_o  = valid_r;
  assign index_o  = index_r;
  assign offset_o = offset_r;
  assign stride_o = stride_r;

endmodule

// ===== verif/tb_broadcast_source_index.sv =====
// Self-checking testbench for the broadcast source index address generator.
`timescale 1ns / 1ps

module tb_broadcast_source_index;

  localparam int MAX_RANK   = bsi_pkg::MAX_RANK;
  localparam int INDEX_BITS = bsi_pkg::INDEX_BITS;
  localparam int ADDR_BITS  = bsi_pkg::ADDR_BITS;
  localparam int DATA_BITS  = bsi_pkg::DATA_BITS;
  localparam int RANK_BITS  = bsi_pkg::RANK_BITS;
  localparam int SIZE_BITS  = bsi_pkg::SIZE_BITS;
  localparam int MASK_BITS  = bsi_pkg::MASK_BITS;
  localparam int SIZE_REGS  = bsi_pkg::SIZE_REGS;

  localparam int LATENCY  = MAX_RANK * (INDEX_BITS + 1);
  localparam int WATCHDOG = 20000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [INDEX_BITS-1:0] in_target_index = '0;
  logic                  out_valid;
  logic [INDEX_BITS-1:0] out_source_offset;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [ADDR_BITS-1:0]  paddr = '0;
  logic [DATA_BITS-1:0]  pwdata = '0;
  logic [DATA_BITS-1:0]  prdata;
  logic                  pready;

  broadcast_source_index dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_target_index(in_target_index), .out_valid(out_valid),
    .out_source_offset(out_source_offset), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .pready(pready)
  );

  always #5 clk = ~clk;

  // Local copy of the configuration registers.
  logic [RANK_BITS-1:0] shadow_rank = 3'd4;
  logic [SIZE_BITS-1:0] shadow_size [SIZE_REGS] = '{default: 16'd1};
  logic [MASK_BITS-1:0] shadow_mask = '0;

  logic [INDEX_BITS-1:0] index_queue [$];
  logic [INDEX_BITS-1:0] offset_queue [$];
  int  idle_pct = 0;
  int  errors = 0;
  int  quiet_cycles = 0;
  bit  stim_done = 1'b0;

  // Busy as seen at the last rising edge, so acceptance is judged there.
  logic busy_sampled = 1'b0;

  // Computes the source offset that a target index maps to.
  function automatic logic [INDEX_BITS-1:0] source_offset_of(
      logic [INDEX_BITS-1:0] target);
    longint unsigned idx;
    longint unsigned sz;
    longint unsigned pos;
    longint unsigned offset;
    longint unsigned stride;
    int r;
    idx = target;
    offset = 0;
    stride = 1;
    r = (shadow_rank > MAX_RANK) ? MAX_RANK : shadow_rank;
    for (int j = r - 1; j >= 0; j--) begin
      sz = (shadow_size[j] == 0) ? 1 : shadow_size[j];
      pos = idx % sz;
      idx = idx / sz;
      if (!shadow_mask[j]) begin
        offset += pos * stride;
        stride *= sz;
      end
    end
    return offset[INDEX_BITS-1:0];
  endfunction

  // Driver: presents pending indexes, changing inputs on the falling edge.
  always @(negedge clk) begin
    if (rst_n && start && !busy_sampled) begin
      void'(index_queue.pop_front());
    end
    if (rst_n && index_queue.size() > 0 && $urandom_range(99) >= idle_pct) begin
      start <= 1'b1;
      in_target_index <= index_queue[0];
    end else begin
      start <= 1'b0;
      in_target_index <= INDEX_BITS'($urandom());
    end
  end

  // Predictor: records the expected offset of every accepted transaction.
  always @(posedge clk) begin
    busy_sampled <= busy;
    if (rst_n && start && !busy)
      offset_queue.push_back(source_offset_of(in_target_index));
  end

  // Monitor: checks every result transaction against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (offset_queue.size() == 0) begin
        $error("unexpected result: source_offset actual %0h", out_source_offset);
        errors++;
      end else begin
        logic [INDEX_BITS-1:0] want;
        want = offset_queue.pop_front();
        if (want !== out_source_offset) begin
          $error("source_offset expected %0h actual %0h", want, out_source_offset);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with work pending but no accepted transaction or result.
  always @(posedge clk) begin
    if ((rst_n && start && !busy) || out_valid || stim_done)
      quiet_cycles <= 0;
    else if (rst_n && (index_queue.size() > 0 || offset_queue.size() > 0))
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Writes one register over the APB-style port.
  task automatic write_reg(logic [2:0] reg_index, logic [DATA_BITS-1:0] value);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= ADDR_BITS'(reg_index) << 2;
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (reg_index)
      bsi_pkg::REG_RANK:  shadow_rank = value[RANK_BITS-1:0];
      bsi_pkg::REG_SIZE0: shadow_size[0] = value[SIZE_BITS-1:0];
      bsi_pkg::REG_SIZE1: shadow_size[1] = value[SIZE_BITS-1:0];
      bsi_pkg::REG_SIZE2: shadow_size[2] = value[SIZE_BITS-1:0];
      bsi_pkg::REG_SIZE3: shadow_size[3] = value[SIZE_BITS-1:0];
      bsi_pkg::REG_MASK:  shadow_mask = value[MASK_BITS-1:0];
      default: ;
    endcase
  endtask

  // Waits until every queued index is accepted and every result is back.
  task automatic drain();
    while (index_queue.size() > 0 || offset_queue.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Picks a dimension size, mostly small, sometimes extreme or zero.
  function automatic logic [DATA_BITS-1:0] pick_size();
    case ($urandom_range(9))
      0: return 0;
      1: return 16'hFFFF;
      2: return 1;
      3: return $urandom_range(256, 65535) | ($urandom() & 32'hFFFF_0000);
      default: return $urandom_range(2, 40);
    endcase
  endfunction

  initial begin
    logic [2:0] size_regs [SIZE_REGS];
    size_regs = '{bsi_pkg::REG_SIZE0, bsi_pkg::REG_SIZE1,
                  bsi_pkg::REG_SIZE2, bsi_pkg::REG_SIZE3};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part: index extremes under the reset configuration,
    // then a small shape with a broadcast dimension, overflow and wrap.
    index_queue.push_back('0);
    index_queue.push_back('1);
    drain();
    write_reg(bsi_pkg::REG_RANK, 3);
    write_reg(bsi_pkg::REG_SIZE0, 2);
    write_reg(bsi_pkg::REG_SIZE1, 3);
    write_reg(bsi_pkg::REG_SIZE2, 4);
    write_reg(bsi_pkg::REG_MASK, 4'b1010);
    for (int i = 0; i < 8; i++) index_queue.push_back(INDEX_BITS'(i * 5));
    index_queue.push_back('1);
    drain();
    // Zero rank gives offset zero; rank above the limit clamps.
    write_reg(bsi_pkg::REG_RANK, 0);
    index_queue.push_back(24'h123456);
    drain();
    write_reg(bsi_pkg::REG_RANK, 7);
    write_reg(bsi_pkg::REG_SIZE3, 0);
    write_reg(bsi_pkg::REG_SIZE0, 16'hFFFF);
    write_reg(bsi_pkg::REG_MASK, 4'b0000);
    index_queue.push_back('1);
    index_queue.push_back(24'hAAAAAA);
    index_queue.push_back(24'h555555);
    drain();
    write_reg(bsi_pkg::REG_MASK, 4'b1111);
    index_queue.push_back(24'h00FFFF);
    drain();

    // Random part: phases with new shapes and different idle rates.
    for (int phase = 0; phase < 12; phase++) begin
      case (phase % 4)
        0: idle_pct = 0;
        1: idle_pct = 60;
        2: idle_pct = 0;
        default: idle_pct = 23;
      endcase
      write_reg(bsi_pkg::REG_RANK, $urandom_range(7));
      foreach (size_regs[j]) write_reg(size_regs[j], pick_size());
      write_reg(bsi_pkg::REG_MASK, $urandom());
      for (int i = 0; i < 78; i++) begin
        if ($urandom_range(3) == 0) index_queue.push_back(INDEX_BITS'($urandom()));
        else index_queue.push_back(INDEX_BITS'($urandom_range(0, 4000)));
      end
      drain();
    end

    stim_done = 1'b1;
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0 && offset_queue.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/bsi_pkg.sv
hdl/bsi_regs.sv
hdl/bsi_divider.sv
hdl/bsi_accum.sv
hdl/broadcast_source_index.sv
verif/tb_broadcast_source_index.sv
